>>> rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the deque block
// Item layouts of both channels, operation codes and default sizes.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] popped_value;
        logic               success;
        logic               now_empty;
        logic [COUNT_W-1:0] entry_count;
    } out_item_t;

endpackage

>>> rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: operation sequencer
// Keeps the ring pointers and steps one shared compare unit and the entry
// memory through pushes, pops, scans and the gap-closing shift of a delete.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  deq_pkg::in_item_t        cmd,
    output logic                     idle,
    output logic                     res_valid,
    input  logic                     res_ack,
    output deq_pkg::out_item_t       res,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output logic [DATA_WIDTH-1:0]    ram_wdata,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  logic [DATA_WIDTH-1:0]    ram_rdata
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POPW,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [KIND_W-1:0]     op_reg, op_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         scan_reg, scan_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]         sh_rd_reg, sh_rd_next;
    logic                  sh_wv_reg, sh_wv_next;
    logic [AW-1:0]         sh_wr_reg, sh_wr_next;
    logic                  ok_reg, ok_next;
    logic [DATA_WIDTH-1:0] popped_reg, popped_next;

    logic [AW-1:0] scan_idx;
    logic [AW-1:0] last_idx;
    logic          scan_issue;
    logic          sh_issue;
    logic          hit;

    // Logical position (0 is the front) to physical ring address.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (AW + 1)'(DEPTH))
        begin
            sum = sum - (AW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
        return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    // Scan order is front, back, then the middle from front to back, so the
    // first hit is exactly the entry a delete has to remove.
    assign last_idx   = AW'(count_reg - CW'(1));
    assign scan_idx   = (scan_reg == '0) ? '0 :
                        (scan_reg == CW'(1)) ? last_idx : AW'(scan_reg - CW'(1));
    assign scan_issue = (scan_reg < count_reg);
    assign sh_issue   = (sh_rd_reg < count_reg);
    assign hit        = cmp_vld_reg && (ram_rdata == word_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        word_next    = word_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        sh_rd_next   = sh_rd_reg;
        sh_wv_next   = 1'b0;
        sh_wr_next   = sh_wr_reg;
        ok_next      = ok_reg;
        popped_next  = popped_reg;
        ram_we       = 1'b0;
        ram_waddr    = phys(head_reg, sh_wr_reg);
        ram_wdata    = ram_rdata;
        ram_raddr    = phys(head_reg, scan_idx);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.kind;
                    word_next   = DATA_WIDTH'(cmd.value);
                    ok_next     = 1'b0;
                    popped_next = '0;
                    scan_next   = '0;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (op_reg)
                    KIND_PUSH_FRONT:
                    begin
                        if (count_reg < CW'(DEPTH))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = ring_dec(head_reg);
                            ram_wdata  = word_reg;
                            head_next  = ring_dec(head_reg);
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    KIND_PUSH_BACK:
                    begin
                        if (count_reg < CW'(DEPTH))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = phys(head_reg, AW'(count_reg));
                            ram_wdata  = word_reg;
                            count_next = count_reg + CW'(1);
                            ok_next    = 1'b1;
                        end
                    end
                    KIND_POP_FRONT:
                    begin
                        ram_raddr = head_reg;
                        if (count_reg != '0)
                        begin
                            state_next = ST_POPW;
                        end
                    end
                    KIND_POP_BACK:
                    begin
                        ram_raddr = phys(head_reg, last_idx);
                        if (count_reg != '0)
                        begin
                            state_next = ST_POPW;
                        end
                    end
                    KIND_DELETE, KIND_SEARCH:
                    begin
                        state_next = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_POPW:
            begin
                popped_next = ram_rdata;
                ok_next     = 1'b1;
                count_next  = count_reg - CW'(1);
                if (op_reg == KIND_POP_FRONT)
                begin
                    head_next = ring_inc(head_reg);
                end
                state_next = ST_DONE;
            end

            ST_SCAN:
            begin
                // Read one entry per cycle; compare the one read last cycle.
                if (scan_issue)
                begin
                    scan_next    = scan_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_idx;
                end
                if (hit)
                begin
                    ok_next      = 1'b1;
                    cmp_vld_next = 1'b0;
                    if (op_reg != KIND_DELETE)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cmp_idx_reg == '0)
                    begin
                        head_next  = ring_inc(head_reg);
                        count_next = count_reg - CW'(1);
                        state_next = ST_DONE;
                    end
                    else if (cmp_idx_reg == last_idx)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        sh_rd_next = CW'(cmp_idx_reg) + CW'(1);
                        state_next = ST_SHIFT;
                    end
                end
                else if (!scan_issue && !cmp_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT:
            begin
                // Move each later entry one place toward the front.
                ram_raddr = phys(head_reg, AW'(sh_rd_reg));
                if (sh_wv_reg)
                begin
                    ram_we = 1'b1;
                end
                if (sh_issue)
                begin
                    sh_rd_next = sh_rd_reg + CW'(1);
                    sh_wv_next = 1'b1;
                    sh_wr_next = AW'(sh_rd_reg - CW'(1));
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            sh_wv_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            sh_wv_reg   <= sh_wv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        word_reg    <= word_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        sh_rd_reg   <= sh_rd_next;
        sh_wr_reg   <= sh_wr_next;
        ok_reg      <= ok_next;
        popped_reg  <= popped_next;
    end

    assign idle             = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_DONE);
    assign res.popped_value = VALUE_W'(popped_reg);
    assign res.success      = ok_reg;
    assign res.now_empty    = (count_reg == '0);
    assign res.entry_count  = COUNT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_idle_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> $stable(count_reg) && $stable(head_reg))
        else $error("pointers moved while idle");

    a_ack_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ack) |=> idle)
        else $error("sequencer did not return to idle after result");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXEC || state_reg == ST_SHIFT))
        else $error("memory write outside push or shift");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == ST_EXEC ||
                                 $past(state_reg) == ST_POPW ||
                                 $past(state_reg) == ST_SCAN ||
                                 $past(state_reg) == ST_SHIFT))
        else $error("count changed outside an operation");

endmodule

>>> rtl/core/deque_with_search_delete.sv
// ----------------------------------------------------------------------------
// deque_with_search_delete: bounded deque with search and delete by value
// Holds up to DEPTH words in order and runs one operation per input item.
// ----------------------------------------------------------------------------
// Usage: an input item (kind, value) is taken when in_valid is high and
// in_stall is low. Every item yields exactly one output item on the out
// channel, taken when out_valid is high and out_stall is low.
// Items are handled one at a time: in_stall stays high from acceptance until
// the sequencer has handed its result to the output register. A push or an
// unused kind finishes in the execute state, a pop waits for its read data,
// a search scans up to count entries, and a delete that closes a gap in the
// middle also shifts each later entry. in_stall falls as the result is loaded
// into the output register, so the next item can be taken while it is shown.
// The scan and the shift both go through the single read port of the entry
// memory, one entry per cycle, so that port sets the speed of search and
// delete. The output register lets the next item be accepted while a result
// waits. When out_stall holds, the result stays put and the next finished
// result waits inside the sequencer, so nothing is lost or repeated.
// Reset empties the deque at once (head and count cleared); entry storage is
// not cleared, since no entry is read before a push has written it.
// ----------------------------------------------------------------------------
module deque_with_search_delete #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  deq_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output deq_pkg::out_item_t out_item
);

    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                  seq_idle;
    logic                  res_valid;
    logic                  res_ack;
    out_item_t             res;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    // A new item is taken only while the sequencer is idle.
    assign in_stall = !seq_idle;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && seq_idle),
        .cmd       (in_item),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register loads whenever it is empty or being emptied.
    assign res_ack = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
